/* hw/rtl/dfs_pkg.sv */
// shared constants, types and helpers for the delimiter field splitter
package dfs_pkg;

  // widest separator and width of position counters
  localparam int MaxSep = 4;
  localparam int PosBits = 16;
  localparam int SepIdxW = (MaxSep > 1) ? $clog2(MaxSep) : 1;
  localparam int LenW = $clog2(MaxSep + 1);
  localparam int SepBytesW = 32;
  localparam int SepLenW = 3;
  localparam int OutW = 16;
  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [OutW-1:0] PartMax = '1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEP_BYTES = 1'b0,
    CFG_SEP_LEN   = 1'b1
  } cfg_idx_t;

  // c-locale whitespace: tab, newline, vertical tab, form feed, return, space
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // saturate a sum that carries one extra bit
  function automatic logic [PosBits-1:0] sat_pos(input logic [PosBits:0] s);
    return s[PosBits] ? PosMax : s[PosBits-1:0];
  endfunction

endpackage

/* hw/rtl/delimiter_field_splitter_core.sv */
// delimiter field splitter: cuts a byte stream at a separator and trims parts
//
// Usage: bytes of a string arrive on the in_ channel one item each; an item
// with in_is_end set closes the string. The user must write the separator
// (1 to 4 bytes, first byte in the low bits) and its length on the cfg_ port
// only while the block is idle; the block itself does not enforce this.
// For every part the block sends one item on the out_ channel: part number,
// offset of the first non-whitespace byte (or the raw start for a blank
// part), trimmed length, a blank flag and a final flag. A part is sent with
// the item that carries the last separator byte, or with the end item; an
// empty last part gives nothing. An accepted item passes the input register,
// then the result register, from which its result is taken.
// Throughput: one item per cycle while out_stall holds no result, set by the
// single registered pass over the separator window and the part counters.
// Stalls: a result held by out_stall parks in the output register; one more
// item waits in the input register, after which in_stall rises.
// Reset: rst_n (synchronous, active low) empties both registers, clears all
// per-string state and loads separator ',' with length 1.
module delimiter_field_splitter_core
  import dfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [SepBytesW-1:0] cfg_wdata,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_is_end,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OutW-1:0]      out_part_number,
  output logic [OutW-1:0]      out_start_offset,
  output logic [OutW-1:0]      out_trimmed_length,
  output logic                 out_is_blank,
  output logic                 out_is_final
);

  // configuration registers
  logic [SepBytesW-1:0] sep_bytes_r;
  logic [SepLenW-1:0]   sep_len_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // per-string state
  logic [PosBits-1:0] byte_pos_r, byte_pos_nxt;
  logic [PosBits-1:0] part_start_r, part_start_nxt;
  logic [7:0]         recent_r [MaxSep];
  logic [7:0]         recent_nxt [MaxSep];
  logic [PosBits-1:0] in_part_r, in_part_nxt;
  logic [PosBits-1:0] first_ns_r, first_ns_nxt;
  logic [PosBits-1:0] last_ns_r, last_ns_nxt;
  logic               seen_ns_r, seen_ns_nxt;
  logic [OutW-1:0]    part_cnt_r, part_cnt_nxt;

  // result register
  logic            out_valid_r;
  logic [OutW-1:0] out_num_r, out_start_r, out_len_r;
  logic            out_blank_r, out_final_r;

  logic               advance;
  logic               produce;
  logic               match;
  logic [LenW-1:0]    eff_len;
  logic [PosBits-1:0] n_byte;
  logic [PosBits-1:0] pend;
  logic               em_seen;
  logic [PosBits-1:0] em_first, em_last;
  logic [SepIdxW-1:0] widx;
  logic [PosBits:0]   psum;

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  // clamp the separator length into 1..MaxSep
  always_comb begin
    if (sep_len_r == '0) begin
      eff_len = LenW'(1);
    end else if (32'(sep_len_r) > MaxSep) begin
      eff_len = LenW'(MaxSep);
    end else begin
      eff_len = LenW'(sep_len_r);
    end
  end

  // byte count of the part including this byte, and bytes still pending at end
  assign n_byte = sat_pos({1'b0, in_part_r} + (PosBits+1)'(1));
  assign pend = (in_part_r < PosBits'(eff_len - LenW'(1))) ?
                in_part_r : PosBits'(eff_len - LenW'(1));

  // shifted window, newest byte first
  always_comb begin
    recent_nxt[0] = s1_byte_r;
    for (int k = 1; k < MaxSep; k++) begin
      recent_nxt[k] = recent_r[k-1];
    end
  end

  // separator compare over the new window
  always_comb begin
    logic [SepIdxW-1:0] idx;
    logic [7:0]         sb;
    idx = '0;
    sb = '0;
    match = (n_byte >= PosBits'(eff_len));
    for (int k = 0; k < MaxSep; k++) begin
      idx = SepIdxW'(eff_len - LenW'(1) - LenW'(k));
      sb = (k < 4) ? sep_bytes_r[8*(k%4) +: 8] : 8'd0;
      if ((LenW'(k) < eff_len) && (recent_nxt[idx] != sb)) begin
        match = 1'b0;
      end
    end
  end

  // trimming state after committing the bytes held back at the end marker
  always_comb begin
    logic [PosBits:0] s;
    s = '0;
    em_seen = seen_ns_r;
    em_first = first_ns_r;
    em_last = last_ns_r;
    for (int i = MaxSep - 1; i >= 0; i--) begin
      s = {1'b0, part_start_r} + {1'b0, in_part_r} - (PosBits+1)'(i) - (PosBits+1)'(1);
      if ((PosBits'(i) < pend) && !is_space(recent_r[i])) begin
        if (!em_seen) begin
          em_first = sat_pos(s);
          em_seen = 1'b1;
        end
        em_last = sat_pos(s);
      end
    end
  end

  // oldest byte that can no longer open a separator and its position
  assign widx = SepIdxW'(eff_len - LenW'(1));
  assign psum = {1'b0, part_start_r} + {1'b0, n_byte} - (PosBits+1)'(eff_len);

  // next state and result
  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    part_start_nxt = part_start_r;
    in_part_nxt    = in_part_r;
    first_ns_nxt   = first_ns_r;
    last_ns_nxt    = last_ns_r;
    seen_ns_nxt    = seen_ns_r;
    part_cnt_nxt   = part_cnt_r;
    produce        = 1'b0;
    if (s1_end_r) begin
      produce        = (in_part_r != '0);
      byte_pos_nxt   = '0;
      part_start_nxt = '0;
      in_part_nxt    = '0;
      first_ns_nxt   = '0;
      last_ns_nxt    = '0;
      seen_ns_nxt    = 1'b0;
      part_cnt_nxt   = '0;
    end else begin
      byte_pos_nxt = sat_pos({1'b0, byte_pos_r} + (PosBits+1)'(1));
      if (match) begin
        produce        = 1'b1;
        part_cnt_nxt   = (part_cnt_r != PartMax) ? part_cnt_r + OutW'(1) : part_cnt_r;
        in_part_nxt    = '0;
        first_ns_nxt   = '0;
        last_ns_nxt    = '0;
        seen_ns_nxt    = 1'b0;
        part_start_nxt = byte_pos_nxt;
      end else begin
        in_part_nxt = n_byte;
        if ((n_byte >= PosBits'(eff_len)) && !is_space(recent_nxt[widx])) begin
          if (!seen_ns_r) begin
            first_ns_nxt = sat_pos(psum);
            seen_ns_nxt  = 1'b1;
          end
          last_ns_nxt = sat_pos(psum);
        end
      end
    end
  end

  // result fields for the part being closed
  logic            res_seen;
  logic [PosBits-1:0] res_first, res_last;
  assign res_seen  = s1_end_r ? em_seen : seen_ns_r;
  assign res_first = s1_end_r ? em_first : first_ns_r;
  assign res_last  = s1_end_r ? em_last : last_ns_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r <= SepBytesW'(44);
      sep_len_r   <= SepLenW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SEP_BYTES: sep_bytes_r <= cfg_wdata;
        CFG_SEP_LEN:   sep_len_r <= cfg_wdata[SepLenW-1:0];
        default:       sep_len_r <= sep_len_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_is_end;
    end
  end

  // per-string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      part_start_r <= '0;
      in_part_r    <= '0;
      first_ns_r   <= '0;
      last_ns_r    <= '0;
      seen_ns_r    <= 1'b0;
      part_cnt_r   <= '0;
      for (int k = 0; k < MaxSep; k++) begin
        recent_r[k] <= '0;
      end
    end else if (advance) begin
      byte_pos_r   <= byte_pos_nxt;
      part_start_r <= part_start_nxt;
      in_part_r    <= in_part_nxt;
      first_ns_r   <= first_ns_nxt;
      last_ns_r    <= last_ns_nxt;
      seen_ns_r    <= seen_ns_nxt;
      part_cnt_r   <= part_cnt_nxt;
      if (!s1_end_r) begin
        for (int k = 0; k < MaxSep; k++) begin
          recent_r[k] <= recent_nxt[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= produce;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_num_r   <= part_cnt_r;
      out_final_r <= s1_end_r;
      out_blank_r <= !res_seen;
      out_start_r <= res_seen ? OutW'(res_first) : OutW'(part_start_r);
      out_len_r   <= res_seen ? OutW'(res_last - res_first + PosBits'(1)) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_part_number    = out_num_r;
  assign out_start_offset   = out_start_r;
  assign out_trimmed_length = out_len_r;
  assign out_is_blank       = out_blank_r;
  assign out_is_final       = out_final_r;

endmodule

/* hw/rtl/dfs_checker.sv */
// port-level checks for the delimiter field splitter, bound to the top level
module dfs_checker
  import dfs_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [OutW-1:0] out_part_number,
  input logic [OutW-1:0] out_start_offset,
  input logic [OutW-1:0] out_trimmed_length,
  input logic            out_is_blank,
  input logic            out_is_final
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_part_number) &&
      $stable(out_start_offset) && $stable(out_trimmed_length) &&
      $stable(out_is_blank) && $stable(out_is_final))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // a fresh result has an accepted item behind it
  a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted item");

  // the part after a final one opens a new string
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_final |=> !out_valid || out_part_number == '0)
    else $error("part numbering did not restart");

endmodule

bind delimiter_field_splitter_core dfs_checker u_dfs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_part_number    (out_part_number),
  .out_start_offset   (out_start_offset),
  .out_trimmed_length (out_trimmed_length),
  .out_is_blank       (out_is_blank),
  .out_is_final       (out_is_final)
);
